// ===== rtl/adc_table_search_interpolate_macros.svh =====
// Assertion macros for the ADC table search and interpolation block.
// Included by the top level; no other dependencies.
`ifndef ADC_TABLE_SEARCH_INTERPOLATE_MACROS_SVH
`define ADC_TABLE_SEARCH_INTERPOLATE_MACROS_SVH

`ifndef SYNTHESIS
`define ATSI_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ATSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ATSI_ASSERT(label, clk, rst_n, prop)
`define ATSI_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/atsi_pkg.sv =====
// Shared types and constants for the ADC table search and interpolation block.
// No dependencies.
package atsi_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CFG_W      = 7;
  localparam int OFFSET_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET = 2'd3;

  localparam logic [CFG_W-1:0]    ENTRIES_USED_RST = 7'd64;
  localparam logic [CFG_W-1:0]    UPPER_LIMIT_RST  = 7'd64;
  localparam logic [CFG_W-1:0]    LOWER_LIMIT_RST  = 7'd0;
  localparam logic [OFFSET_W-1:0] SCALE_OFFSET_RST = 10'd0;

  localparam logic [1:0] ST_INTERP   = 2'd0;
  localparam logic [1:0] ST_CLAMP_LO = 2'd1;
  localparam logic [1:0] ST_CLAMP_HI = 2'd2;
  localparam logic [1:0] ST_FLAG     = 2'd3;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  entry_slot;
    logic [11:0] entry_value;
    logic [11:0] sample;
  } adc_in_t;

  typedef struct packed {
    logic signed [15:0] reading;
    logic [1:0]         status;
  } adc_out_t;

endpackage

// ===== rtl/adc_table_search_interpolate.sv =====
// Top level of the ADC table search and interpolation; needs atsi_pkg and the macros header.
// A convert beat runs k search steps (k <= 6 at the defaults); unless clamped, it then
// reads the segment and, unless the span is zero, runs a SAMPLE_BITS + 4 step divider.
// Write beats go back to back and give no result. A convert stalls the input until its
// result is registered; the next beat is taken in the cycle after. Reset is asynchronous,
// active low: it resets state, output valid and config registers; table left as is.
`include "adc_table_search_interpolate_macros.svh"

module adc_table_search_interpolate #(
  parameter int TABLE_DEPTH = atsi_pkg::TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS = atsi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  atsi_pkg::adc_in_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output atsi_pkg::adc_out_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [atsi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [atsi_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int IDXW  = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW  = (IDXW > atsi_pkg::CFG_W) ? IDXW : atsi_pkg::CFG_W;
  localparam int QW    = SB + 4;
  localparam int NW    = SB + 5;
  localparam int DW    = SB + 5;
  localparam int CNTW  = $clog2(QW + 1);
  localparam int TW0   = (CMPW + 1 > atsi_pkg::OFFSET_W) ? CMPW + 1 : atsi_pkg::OFFSET_W;
  localparam int TW    = TW0 + 1;
  localparam int FW    = QW + 1;
  localparam int VW0   = (FW > TW + 4) ? FW : TW + 4;
  localparam int VW    = ((VW0 > 17) ? VW0 : 17) + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_CMP     = 4'd2;
  localparam logic [3:0] S_CLAMP   = 4'd3;
  localparam logic [3:0] S_RDP     = 4'd4;
  localparam logic [3:0] S_RDE     = 4'd5;
  localparam logic [3:0] S_SPAN    = 4'd6;
  localparam logic [3:0] S_NUM     = 4'd7;
  localparam logic [3:0] S_DIVINIT = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  // Configuration registers
  logic [atsi_pkg::CFG_W-1:0]           entries_used_q;
  logic [atsi_pkg::CFG_W-1:0]           upper_limit_q;
  logic [atsi_pkg::CFG_W-1:0]           lower_limit_q;
  logic signed [atsi_pkg::OFFSET_W-1:0] scale_offset_q;

  // Sequencer and datapath
  logic [3:0]              state_q, state_d;
  logic [SB-1:0]           table_mem [TABLE_DEPTH];
  logic [SB-1:0]           rd_q;
  logic [AW-1:0]           rd_addr;
  logic [SB-1:0]           smp_q;
  logic [CMPW-1:0]         n_q, lo_q, hi_q, bsel_q;
  logic [SB-1:0]           prev_q;
  logic signed [SB:0]      span_q;
  logic signed [NW-1:0]    num_q;
  logic                    neg_q;
  logic [SB-1:0]           rem_q, dvs_q;
  logic [QW-1:0]           quo_q;
  logic [CNTW-1:0]         cnt_q;
  logic [1:0]              status_q;
  logic                    out_valid_q, out_valid_d;
  atsi_pkg::adc_out_t      out_q, out_d;

  logic                    in_acc, out_acc, out_load;
  logic [SB+11:0]          smp_wide, val_wide;
  logic [CMPW-1:0]         slot_x, upper_x, lower_x, used_x, n_in, idx_m1;
  logic [CMPW:0]           mid_sum;
  logic [CMPW-1:0]         mid;
  logic [DW-1:0]           alu_a, alu_b;
  logic [DW:0]             alu_diff;
  logic                    alu_borrow;
  logic [SB:0]             rem_sh;
  logic signed [NW-1:0]    d_x, num_d, num_abs;
  logic signed [SB:0]      span_abs;
  logic signed [FW-1:0]    frac;
  logic signed [TW-1:0]    t_idx;
  logic signed [TW+3:0]    base_x, base;
  logic signed [VW-1:0]    val;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign smp_wide = (SB + 12)'(in_data_i.sample);
  assign val_wide = (SB + 12)'(in_data_i.entry_value);
  assign slot_x   = CMPW'(in_data_i.entry_slot);
  assign upper_x  = CMPW'(upper_limit_q);
  assign lower_x  = CMPW'(lower_limit_q);
  assign used_x   = CMPW'(entries_used_q);

  always_comb begin
    if (used_x < CMPW'(2)) begin
      n_in = CMPW'(2);
    end else if (used_x > CMPW'(TABLE_DEPTH)) begin
      n_in = CMPW'(TABLE_DEPTH);
    end else begin
      n_in = used_x;
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CMPW:1];
  assign idx_m1  = bsel_q - CMPW'(1);

  // Shared subtractor: search compare, span, numerator difference and divider step.
  assign rem_sh = {rem_q, quo_q[QW-1]};
  always_comb begin
    case (state_q)
      S_CMP: begin
        alu_a = DW'(rd_q);
        alu_b = DW'(smp_q);
      end
      S_SPAN: begin
        alu_a = DW'(prev_q);
        alu_b = DW'(rd_q);
      end
      S_NUM: begin
        alu_a = DW'(prev_q);
        alu_b = DW'(smp_q);
      end
      S_DIV: begin
        alu_a = DW'(rem_sh);
        alu_b = DW'(dvs_q);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end
  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[DW];

  assign d_x      = {{4{alu_diff[SB]}}, alu_diff[SB:0]};
  assign num_d    = (d_x <<< 3) + (d_x <<< 1);
  assign num_abs  = num_q[NW-1] ? -num_q : num_q;
  assign span_abs = span_q[SB] ? -span_q : span_q;

  always_comb begin
    case (state_q)
      S_RD:    rd_addr = mid[AW-1:0];
      S_RDP:   rd_addr = idx_m1[AW-1:0];
      default: rd_addr = bsel_q[AW-1:0];
    endcase
  end

  // Result assembly: 10*(index+offset-1) plus the signed fraction, saturated to 16 bits.
  assign frac   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign t_idx  = TW'($signed({1'b0, bsel_q})) + TW'(scale_offset_q) - TW'(1);
  assign base_x = (TW + 4)'(t_idx);
  assign base   = (base_x <<< 3) + (base_x <<< 1);
  assign val    = VW'(frac) + VW'(base);

  always_comb begin
    out_d = out_q;
    if (val > VW'(32'sd32767)) begin
      out_d.reading = 16'sh7FFF;
      out_d.status  = atsi_pkg::ST_FLAG;
    end else if (val < VW'(-32'sd32768)) begin
      out_d.reading = -16'sh8000;
      out_d.status  = atsi_pkg::ST_FLAG;
    end else begin
      out_d.reading = val[15:0];
      out_d.status  = status_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_data_i.mode == atsi_pkg::MODE_CONVERT)) begin
          state_d = S_RD;
        end
      end
      S_RD:    state_d = (lo_q <= hi_q) ? S_CMP : S_CLAMP;
      S_CMP:   state_d = S_RD;
      S_CLAMP: begin
        if (lo_q >= upper_x || lo_q >= n_q || lo_q <= lower_x) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RDP;
        end
      end
      S_RDP:     state_d = S_RDE;
      S_RDE:     state_d = S_SPAN;
      S_SPAN:    state_d = S_NUM;
      S_NUM:     state_d = S_DIVINIT;
      S_DIVINIT: state_d = (span_q == '0) ? S_OUT : S_DIV;
      S_DIV:     state_d = (cnt_q == CNTW'(1)) ? S_OUT : S_DIV;
      S_OUT:     state_d = out_load ? S_IDLE : S_OUT;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      entries_used_q <= atsi_pkg::ENTRIES_USED_RST;
      upper_limit_q  <= atsi_pkg::UPPER_LIMIT_RST;
      lower_limit_q  <= atsi_pkg::LOWER_LIMIT_RST;
      scale_offset_q <= atsi_pkg::SCALE_OFFSET_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          atsi_pkg::CFG_ENTRIES_USED: entries_used_q <= cfg_data_i[atsi_pkg::CFG_W-1:0];
          atsi_pkg::CFG_UPPER_LIMIT:  upper_limit_q  <= cfg_data_i[atsi_pkg::CFG_W-1:0];
          atsi_pkg::CFG_LOWER_LIMIT:  lower_limit_q  <= cfg_data_i[atsi_pkg::CFG_W-1:0];
          atsi_pkg::CFG_SCALE_OFFSET: scale_offset_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Table: one write port from the input beat, one registered read port for the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.mode == atsi_pkg::MODE_WRITE)
        && (slot_x < CMPW'(TABLE_DEPTH))) begin
      table_mem[slot_x[AW-1:0]] <= val_wide[SB-1:0];
    end
    rd_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    case (state_q)
      S_IDLE: begin
        smp_q <= smp_wide[SB-1:0];
        n_q   <= n_in;
        lo_q  <= CMPW'(1);
        hi_q  <= n_in - CMPW'(1);
      end
      S_CMP: begin
        // A borrow means the sample lies above this entry.
        if (alu_borrow) begin
          lo_q <= mid + CMPW'(1);
        end else begin
          hi_q <= mid - CMPW'(1);
        end
      end
      S_CLAMP: begin
        quo_q <= '0;
        neg_q <= 1'b0;
        if (lo_q >= upper_x || lo_q >= n_q) begin
          bsel_q   <= upper_x;
          status_q <= atsi_pkg::ST_CLAMP_HI;
        end else if (lo_q <= lower_x) begin
          bsel_q   <= lower_x;
          status_q <= atsi_pkg::ST_CLAMP_LO;
        end else begin
          bsel_q   <= lo_q;
          status_q <= atsi_pkg::ST_INTERP;
        end
      end
      S_RDE:  prev_q <= rd_q;
      S_SPAN: span_q <= $signed(alu_diff[SB:0]);
      S_NUM:  num_q  <= num_d;
      S_DIVINIT: begin
        rem_q <= '0;
        cnt_q <= CNTW'(QW);
        if (span_q == '0) begin
          status_q <= atsi_pkg::ST_FLAG;
          quo_q    <= '0;
          neg_q    <= 1'b0;
        end else begin
          quo_q <= num_abs[QW-1:0];
          dvs_q <= span_abs[SB-1:0];
          neg_q <= num_q[NW-1] ^ span_q[SB];
        end
      end
      S_DIV: begin
        cnt_q <= cnt_q - CNTW'(1);
        if (!alu_borrow) begin
          rem_q <= alu_diff[SB-1:0];
          quo_q <= {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[SB-1:0];
          quo_q <= {quo_q[QW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  `ATSI_ASSERT_IMPLIES(a_convert_starts, clk_i, rst_ni,
    in_acc && (in_data_i.mode == atsi_pkg::MODE_CONVERT), ##1 (state_q == S_RD))
  `ATSI_ASSERT_IMPLIES(a_search_in_range, clk_i, rst_ni,
    state_q == S_CMP, (mid >= CMPW'(1)) && (mid < n_q))
  `ATSI_ASSERT_IMPLIES(a_segment_valid, clk_i, rst_ni,
    state_q == S_RDP, (bsel_q > lower_x) && (bsel_q < upper_x) && (bsel_q < n_q))
  `ATSI_ASSERT_IMPLIES(a_div_remainder, clk_i, rst_ni,
    state_q == S_DIV, (rem_q < dvs_q) && (cnt_q != '0))

endmodule

// ===== sim/adc_table_search_interpolate_tb.sv =====
// Self-checking testbench for adc_table_search_interpolate: loads calibration tables,
// converts samples under several register settings and checks every reading and status.
// Depends on atsi_pkg and the RTL of the block; reads no files.
module adc_table_search_interpolate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES    = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int NUM_DIRECTED  = 23;
  localparam int NUM_REGS      = 4;

  typedef struct packed {
    logic               mode;
    logic [5:0]         slot;
    logic [11:0]        value;
    logic [11:0]        smp;
    logic               typed;
    logic signed [15:0] reading;
    logic [1:0]         status;
  } stim_row_t;

  // Run at the reset settings against a table that starts with 64*slot in every slot.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd0,    1'b1, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd4095, 1'b1, 16'sd630,  atsi_pkg::ST_CLAMP_HI},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd640,  1'b1, 16'sd100,  atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd32,   1'b1, 16'sd5,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd4032, 1'b1, 16'sd630,  atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd4033, 1'b1, 16'sd630,  atsi_pkg::ST_CLAMP_HI},
    '{atsi_pkg::MODE_WRITE,   6'd1,  12'd0,    12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd0,    1'b1, 16'sd0,    atsi_pkg::ST_FLAG},
    '{atsi_pkg::MODE_WRITE,   6'd0,  12'd4095, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd1,  12'd4094, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd0,    1'b1, 16'sh7fff, atsi_pkg::ST_FLAG},
    '{atsi_pkg::MODE_WRITE,   6'd0,  12'd4094, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd1,  12'd4095, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd0,    1'b1, 16'sh8000, atsi_pkg::ST_FLAG},
    '{atsi_pkg::MODE_WRITE,   6'd0,  12'd0,    12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd1,  12'd64,   12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd63, 12'd4095, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd4095, 1'b1, 16'sd630,  atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd63, 12'd4032, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd1000, 1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd2047, 1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_WRITE,   6'd40, 12'd2600, 12'd0,    1'b0, 16'sd0,    atsi_pkg::ST_INTERP},
    '{atsi_pkg::MODE_CONVERT, 6'd0,  12'd0,    12'd2590, 1'b0, 16'sd0,    atsi_pkg::ST_INTERP}
  };

  localparam logic [atsi_pkg::CFG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
    atsi_pkg::CFG_ENTRIES_USED, atsi_pkg::CFG_UPPER_LIMIT,
    atsi_pkg::CFG_LOWER_LIMIT, atsi_pkg::CFG_SCALE_OFFSET
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            in_valid_i;
  logic                            in_stall_o;
  atsi_pkg::adc_in_t               in_data_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  atsi_pkg::adc_out_t              out_data_o;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [atsi_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [atsi_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // Register copies, table copy and the readings still owed by the block.
  int                 entries_used_q;
  int                 upper_limit_q;
  int                 lower_limit_q;
  int                 scale_offset_q;
  logic [11:0]        cal_shadow [64];
  atsi_pkg::adc_out_t expected_readings [$];

  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          hold_done_at   = -1;
  int          stall_left     = 0;
  bit          quiet_tail     = 1'b0;
  int unsigned cycle_count    = 0;

  adc_table_search_interpolate u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL adc_table_search_interpolate");
      $finish;
    end
  end

  function automatic atsi_pkg::adc_out_t predict_reading(input logic [11:0] smp);
    int                 n;
    int                 lo;
    int                 hi;
    int                 mid;
    int                 prev;
    int                 ent;
    int                 span;
    int                 frac;
    int                 val;
    logic [1:0]         st;
    atsi_pkg::adc_out_t res;
    n = entries_used_q;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    lo = 1;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (smp > cal_shadow[mid]) lo = mid + 1;
      else hi = mid - 1;
    end
    // lo is now the segment index; running off the used entries clamps high.
    if (lo >= upper_limit_q || lo >= n) begin
      val = 10 * (upper_limit_q + scale_offset_q - 1);
      st  = atsi_pkg::ST_CLAMP_HI;
    end else if (lo <= lower_limit_q) begin
      val = 10 * (lower_limit_q + scale_offset_q - 1);
      st  = atsi_pkg::ST_CLAMP_LO;
    end else begin
      prev = int'(cal_shadow[lo-1]);
      ent  = int'(cal_shadow[lo]);
      span = prev - ent;
      frac = 0;
      st   = atsi_pkg::ST_INTERP;
      if (span == 0) st = atsi_pkg::ST_FLAG;
      else frac = (10 * (prev - int'(smp))) / span;
      val = frac + 10 * (lo + scale_offset_q - 1);
      if (val > 32767) begin
        val = 32767;
        st  = atsi_pkg::ST_FLAG;
      end else if (val < -32768) begin
        val = -32768;
        st  = atsi_pkg::ST_FLAG;
      end
    end
    res.reading = 16'(val);
    res.status  = st;
    return res;
  endfunction

  // Offers one beat, waits for it to be taken and updates the prediction.
  task automatic send_item(input atsi_pkg::adc_in_t item, input bit use_typed,
                           input atsi_pkg::adc_out_t typed_out);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.mode == atsi_pkg::MODE_WRITE) begin
      cal_shadow[item.entry_slot] = item.entry_value;
    end else begin
      expected_readings.push_back(use_typed ? typed_out : predict_reading(item.sample));
    end
  endtask

  // Stops offering and lets the block drain and go quiet.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    atsi_pkg::adc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected beat: expected none, got reading %0d status %0d",
                   $time, out_data_o.reading, out_data_o.status);
        end else begin
          want = expected_readings.pop_front();
          if (out_data_o.reading !== want.reading) begin
            mismatch_count++;
            $display("%0t reading mismatch: expected %0d, got %0d",
                     $time, want.reading, out_data_o.reading);
          end
          if (out_data_o.status !== want.status) begin
            mismatch_count++;
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, out_data_o.status);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && (results_seen == 150 || results_seen == 600) &&
                   hold_done_at != results_seen) begin
        // Long hold-off so that the block fills and pushes back on its input.
        hold_done_at = results_seen;
        stall_left   = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left   = $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int                 phase_cfg [NUM_PHASES][NUM_REGS];
    atsi_pkg::adc_in_t  item;
    atsi_pkg::adc_out_t typed_out;
    int                 level;
    int                 step_max;
    int                 val;
    int                 n_conv;
    int                 k;

    phase_cfg = '{
      '{64,  64,  0,   0},
      '{2,   64,  0,   -512},
      '{64,  0,   0,   511},
      '{33,  40,  10,  37},
      '{64,  64,  64,  0},
      '{0,   127, 127, -1},
      '{127, 20,  5,   -200},
      '{0,   0,   0,   0},
      '{0,   0,   0,   0},
      '{64,  64,  0,   5}
    };
    // Two phases take random settings.
    for (int p = 7; p < 9; p++) begin
      phase_cfg[p][0] = $urandom_range(2, 64);
      phase_cfg[p][1] = $urandom_range(0, 70);
      phase_cfg[p][2] = $urandom_range(0, phase_cfg[p][1]);
      phase_cfg[p][3] = int'($urandom_range(0, 1023)) - 512;
    end

    entries_used_q = int'(atsi_pkg::ENTRIES_USED_RST);
    upper_limit_q  = int'(atsi_pkg::UPPER_LIMIT_RST);
    lower_limit_q  = int'(atsi_pkg::LOWER_LIMIT_RST);
    scale_offset_q = int'($signed(atsi_pkg::SCALE_OFFSET_RST));

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= atsi_pkg::CFG_ENTRIES_USED;
    cfg_data_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The table comes out of reset undefined, so every slot is written first.
    for (int s = 0; s < 64; s++) begin
      item             = '0;
      item.mode        = atsi_pkg::MODE_WRITE;
      item.entry_slot  = 6'(s);
      item.entry_value = 12'(64 * s);
      send_item(item, 1'b0, '0);
    end

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      item             = '0;
      item.mode        = DIRECTED_ROWS[r].mode;
      item.entry_slot  = DIRECTED_ROWS[r].slot;
      item.entry_value = DIRECTED_ROWS[r].value;
      item.sample      = DIRECTED_ROWS[r].smp;
      typed_out.reading = DIRECTED_ROWS[r].reading;
      typed_out.status  = DIRECTED_ROWS[r].status;
      send_item(item, DIRECTED_ROWS[r].typed, typed_out);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        for (int r = 0; r < NUM_REGS; r++) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= REG_ORDER[r];
          cfg_data_i  <= atsi_pkg::CFG_DATA_W'(phase_cfg[ph][r]);
          do @(posedge clk_i); while (!cfg_ready_o);
          case (REG_ORDER[r])
            atsi_pkg::CFG_ENTRIES_USED: entries_used_q = phase_cfg[ph][r] & 127;
            atsi_pkg::CFG_UPPER_LIMIT:  upper_limit_q  = phase_cfg[ph][r] & 127;
            atsi_pkg::CFG_LOWER_LIMIT:  lower_limit_q  = phase_cfg[ph][r] & 127;
            atsi_pkg::CFG_SCALE_OFFSET:
              scale_offset_q = int'($signed(10'(phase_cfg[ph][r])));
            default: ;
          endcase
        end
        cfg_valid_i <= 1'b0;
      end
      quiet_tail = (ph == NUM_PHASES - 1);

      // Fresh ascending table, now and then broken by an out-of-order entry.
      step_max = $urandom_range(1, 130);
      level    = $urandom_range(0, 200);
      for (int s = 0; s < 64; s++) begin
        if ($urandom_range(0, 15) == 0) begin
          val = $urandom_range(0, 4095);
        end else begin
          val   = level;
          level = level + int'($urandom_range(0, step_max));
          if (level > 4095) level = 4095;
        end
        item             = '0;
        item.mode        = atsi_pkg::MODE_WRITE;
        item.entry_slot  = 6'(s);
        item.entry_value = 12'(val);
        item.sample      = 12'($urandom);
        send_item(item, 1'b0, '0);
      end

      n_conv = $urandom_range(95, 120);
      for (int c = 0; c < n_conv; c++) begin
        item             = '0;
        item.entry_slot  = 6'($urandom);
        item.entry_value = 12'($urandom);
        if ($urandom_range(0, 15) == 0) begin
          item.mode = atsi_pkg::MODE_WRITE;
        end else begin
          item.mode = atsi_pkg::MODE_CONVERT;
          case ($urandom_range(0, 7))
            0: item.sample = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095;
            1, 2: item.sample = 12'($urandom);
            default: begin
              k   = $urandom_range(0, 63);
              val = int'(cal_shadow[k]) + int'($urandom_range(0, 4)) - 2;
              if (val < 0) val = 0;
              if (val > 4095) val = 4095;
              item.sample = 12'(val);
            end
          endcase
        end
        send_item(item, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS adc_table_search_interpolate");
    end else begin
      $display("FAIL adc_table_search_interpolate");
    end
    $finish;
  end

endmodule
